// ===== design/gof_pkg.sv =====
package gof_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int TIME_W = 48;
  localparam int FRAC_W = 17;
  localparam int QUO_W  = 16;
  localparam int STEP_W = $clog2(QUO_W);

  localparam logic [FRAC_W-1:0] Q16_ONE  = FRAC_W'(65536);
  localparam logic [FRAC_W-1:0] Q16_ZERO = '0;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_ROW   = 2'd2;

  typedef logic [TIME_W-1:0] time_t;

  typedef struct packed {
    time_t t_begin;
    time_t t_end;
  } interval_t;

endpackage

// ===== design/gti_overlap_fraction.sv =====
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   action_i, first_time_i, second_time_i, livetime_i
// out      out_valid_o / out_ready_i fraction_o, exposure_o, in_good_time_o, past_last_o
//
// A clear or a load is finished in the idle state. A history row first scans the table
// entries (one per cycle through the interval memory read port), followed by a 16-step
// restoring divider, skipped when the overlap is whole or empty, and a multiply split into
// high and low partial products. A row on an empty table goes straight to the multiply.
// Reset empties the table at once; entries are never cleared, only the count.
// A new transaction is taken while a finished result still waits in the output register;
// a row whose result is ready waits only if the previous result has not been taken.
module gti_overlap_fraction
  import gof_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [TIME_W-1:0] first_time_i,
  input  logic [TIME_W-1:0] second_time_i,
  input  logic [TIME_W-1:0] livetime_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [FRAC_W-1:0] fraction_o,
  output logic [TIME_W-1:0] exposure_o,
  output logic              in_good_time_o,
  output logic              past_last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_NUM,
    S_CHK,
    S_DIV,
    S_MUL,
    S_OUT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] idx_q;
  logic [STEP_W-1:0] step_q;
  logic             out_valid_q;

  // Interval memory, one read and one write port, registered read data.
  interval_t        mem_q [TABLE_DEPTH];
  interval_t        rd_q;
  logic [IDX_W-1:0] rd_addr;

  time_t             t1_q, t2_q, span_q, dur_q, last_end_q;
  time_t             min_q, sub_q, rem_q;
  logic [QUO_W-1:0]  quo_q;
  logic [FRAC_W-1:0] frac_q;
  logic              past_q;
  logic [48:0]       prod_hi_q;
  logic [32:0]       prod_lo_q;
  logic [FRAC_W-1:0] fraction_q;
  time_t             exposure_q;
  logic              good_q;
  logic              past_last_q;

  logic in_acc, do_load, do_row, out_load;
  logic [CNT_W-1:0] idx_nxt;
  time_t b, e;
  logic lt_t1_b, lt_t2_b, le_t2_e, ge_e_b, gt_t1_e;
  logic skip, hit_one, hit_zero, last_entry;
  logic [TIME_W:0] rem_sh, rem_diff;
  logic            div_take;
  logic [QUO_W-1:0] quo_nxt;
  logic [49:0] exp_sum;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign do_load    = in_acc && (action_i == ACT_LOAD) && (count_q < CNT_W'(TABLE_DEPTH));
  assign do_row     = in_acc && (action_i == ACT_ROW);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign idx_nxt = idx_q + CNT_W'(1);
  // While idle the first entry is fetched ahead; during the scan the next one is.
  assign rd_addr = (state_q == S_CMP) ? idx_nxt[IDX_W-1:0] : '0;

  assign b = rd_q.t_begin;
  assign e = rd_q.t_end;
  assign lt_t1_b = t1_q < b;
  assign lt_t2_b = t2_q < b;
  assign le_t2_e = t2_q <= e;
  assign ge_e_b  = e >= b;
  assign gt_t1_e = t1_q > e;

  assign skip     = lt_t1_b ? lt_t2_b : gt_t1_e;
  assign hit_one  = !lt_t1_b && le_t2_e;
  assign hit_zero = lt_t1_b && !le_t2_e && !ge_e_b;
  assign last_entry = (idx_nxt == count_q);

  assign rem_sh   = {rem_q, 1'b0};
  assign rem_diff = rem_sh - {1'b0, span_q};
  assign div_take = (rem_sh >= {1'b0, span_q});
  assign quo_nxt  = {quo_q[QUO_W-2:0], div_take};

  assign exp_sum = {1'b0, prod_hi_q} + 50'(prod_lo_q[32:16]);

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      mem_q[count_q[IDX_W-1:0]] <= '{t_begin: first_time_i, t_end: second_time_i};
    end
    rd_q <= mem_q[rd_addr];
  end

  // Control and state machine.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          if (in_acc && (action_i == ACT_CLEAR)) begin
            count_q <= '0;
          end
          if (do_load) begin
            count_q <= count_q + CNT_W'(1);
          end
          if (do_row) begin
            state_q <= (count_q == '0) ? S_MUL : S_CMP;
          end
        end
        S_CMP: begin
          idx_q <= idx_nxt;
          if (!skip) begin
            state_q <= (hit_one || hit_zero) ? S_MUL : S_NUM;
          end else if (last_entry) begin
            state_q <= S_MUL;
          end
        end
        S_NUM: state_q <= S_CHK;
        S_CHK: begin
          step_q  <= '0;
          state_q <= (rem_q >= span_q) ? S_MUL : S_DIV;
        end
        S_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(QUO_W - 1)) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      last_end_q <= second_time_i;
    end
    if (do_row) begin
      t1_q   <= first_time_i;
      t2_q   <= second_time_i;
      span_q <= second_time_i - first_time_i;
      if (livetime_i != '0) begin
        dur_q <= livetime_i;
      end else if (second_time_i >= first_time_i) begin
        dur_q <= second_time_i - first_time_i;
      end else begin
        dur_q <= '0;
      end
      // An empty table counts as fully covered; a miss of every entry leaves zero.
      frac_q <= (count_q == '0) ? Q16_ONE : Q16_ZERO;
    end
    case (state_q)
      S_CMP: begin
        if (!skip) begin
          if (hit_one) begin
            frac_q <= Q16_ONE;
          end else if (hit_zero) begin
            frac_q <= Q16_ZERO;
          end
          if (lt_t1_b) begin
            min_q <= le_t2_e ? t2_q : e;
            sub_q <= b;
          end else begin
            min_q <= e;
            sub_q <= t1_q;
          end
        end
      end
      S_NUM: begin
        rem_q <= min_q - sub_q;
        quo_q <= '0;
      end
      S_CHK: begin
        if (rem_q >= span_q) begin
          frac_q <= Q16_ONE;
        end
      end
      S_DIV: begin
        quo_q <= quo_nxt;
        if (div_take) begin
          rem_q <= rem_diff[TIME_W-1:0];
        end else begin
          rem_q <= rem_sh[TIME_W-1:0];
        end
        if (step_q == STEP_W'(QUO_W - 1)) begin
          frac_q <= {1'b0, quo_nxt};
        end
      end
      S_MUL: begin
        prod_hi_q <= 49'(dur_q[47:16]) * 49'(frac_q);
        prod_lo_q <= 33'(dur_q[15:0]) * 33'(frac_q);
        past_q    <= (frac_q == Q16_ZERO) && (t1_q > last_end_q);
      end
      default: ;
    endcase
    if (out_load) begin
      fraction_q  <= frac_q;
      exposure_q  <= (exp_sum[49:48] != 2'b00) ? '1 : exp_sum[TIME_W-1:0];
      good_q      <= (frac_q != Q16_ZERO);
      past_last_q <= past_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fraction_o     = fraction_q;
  assign exposure_o     = exposure_q;
  assign in_good_time_o = good_q;
  assign past_last_o    = past_last_q;

endmodule

// ===== bench/gof_result_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the block and keeps its own copy of the interval table.
// Each row transaction queues the expected result, and each result transaction is
// compared with the oldest entry in that queue.
module gof_result_checker
  import gof_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        action_i,
  input  logic [TIME_W-1:0] first_time_i,
  input  logic [TIME_W-1:0] second_time_i,
  input  logic [TIME_W-1:0] livetime_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [FRAC_W-1:0] fraction_i,
  input  logic [TIME_W-1:0] exposure_i,
  input  logic              in_good_time_i,
  input  logic              past_last_i,
  output int                fail_count_o,
  output int                rows_pending_o
);

  localparam time_t TIME_ALL_ONES = '1;

  typedef struct packed {
    logic [FRAC_W-1:0] fraction;
    time_t             exposure;
    logic              in_good_time;
    logic              past_last;
  } row_result_t;

  time_t       gti_begin [TABLE_DEPTH];
  time_t       gti_end   [TABLE_DEPTH];
  int unsigned gti_count;
  row_result_t result_q[$];
  row_result_t want;
  int          fails;

  // Truncated Q16 quotient; a numerator at or above the span means full coverage.
  function automatic logic [FRAC_W-1:0] overlap_q16(input time_t num, input time_t den);
    logic [TIME_W:0]   rest;
    logic [FRAC_W-1:0] quo;
    if (den == '0 || num >= den) return Q16_ONE;
    rest = {1'b0, num};
    quo  = '0;
    for (int i = 0; i < QUO_W; i++) begin
      rest = rest << 1;
      quo  = quo << 1;
      if (rest >= {1'b0, den}) begin
        rest   = rest - {1'b0, den};
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic time_t weighted_exposure(input time_t dur, input logic [FRAC_W-1:0] frac);
    logic [63:0] sum;
    sum = 64'(dur[TIME_W-1:16]) * 64'(frac) + ((64'(dur[15:0]) * 64'(frac)) >> 16);
    if (sum > 64'(TIME_ALL_ONES)) sum = 64'(TIME_ALL_ONES);
    return time_t'(sum);
  endfunction

  function automatic row_result_t predict_row(input time_t t_start, input time_t t_stop,
                                              input time_t live);
    row_result_t       res;
    logic [FRAC_W-1:0] frac;
    time_t             dur;
    time_t             b;
    time_t             e;
    logic              hit;
    if (gti_count == 0) begin
      frac = Q16_ONE;
    end else begin
      frac = Q16_ZERO;
      hit  = 1'b0;
      // Only the first interval that lies neither wholly before nor wholly after the row counts.
      for (int i = 0; i < gti_count && !hit; i++) begin
        b = gti_begin[i];
        e = gti_end[i];
        if (t_start < b) begin
          if (t_stop >= b) begin
            hit = 1'b1;
            if (t_stop <= e) frac = overlap_q16(t_stop - b, t_stop - t_start);
            else if (e >= b) frac = overlap_q16(e - b, t_stop - t_start);
            else frac = Q16_ZERO;
          end
        end else if (t_start <= e) begin
          hit = 1'b1;
          if (t_stop <= e) frac = Q16_ONE;
          else frac = overlap_q16(e - t_start, t_stop - t_start);
        end
      end
    end
    if (live != '0) dur = live;
    else if (t_stop >= t_start) dur = t_stop - t_start;
    else dur = '0;
    res.fraction     = frac;
    res.exposure     = (frac != Q16_ZERO) ? weighted_exposure(dur, frac) : '0;
    res.in_good_time = (frac != Q16_ZERO);
    res.past_last    = (gti_count != 0) && (frac == Q16_ZERO)
                       && (t_start > gti_end[gti_count - 1]);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gti_count = 0;
      fails     = 0;
      result_q.delete();
      fail_count_o   <= 0;
      rows_pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("result transaction with no row waiting: fraction %0d", fraction_i);
          fails++;
        end else begin
          want = result_q.pop_front();
          if (fraction_i !== want.fraction) begin
            $error("fraction: expected %0d, actual %0d", want.fraction, fraction_i);
            fails++;
          end
          if (exposure_i !== want.exposure) begin
            $error("exposure: expected %0d, actual %0d", want.exposure, exposure_i);
            fails++;
          end
          if (in_good_time_i !== want.in_good_time) begin
            $error("in_good_time: expected %0d, actual %0d", want.in_good_time,
                   in_good_time_i);
            fails++;
          end
          if (past_last_i !== want.past_last) begin
            $error("past_last: expected %0d, actual %0d", want.past_last, past_last_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (action_i)
          ACT_CLEAR: begin
            gti_count = 0;
          end
          ACT_LOAD: begin
            if (gti_count < TABLE_DEPTH) begin
              gti_begin[gti_count] = first_time_i;
              gti_end[gti_count]   = second_time_i;
              gti_count++;
            end
          end
          ACT_ROW: begin
            result_q = {result_q, predict_row(first_time_i, second_time_i, livetime_i)};
          end
          default: begin
          end
        endcase
      end
      fail_count_o   <= fails;
      rows_pending_o <= result_q.size();
    end
  end

endmodule

// ===== bench/gti_overlap_fraction_test.sv =====
`timescale 1ns / 100ps

module gti_overlap_fraction_test;
  import gof_pkg::*;

  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam time_t      TIME_MAX    = '1;
  localparam int         ROW_ITEMS   = 1650;
  localparam int         STALL_LIMIT = 5000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        action = ACT_CLEAR;
  time_t             first_time = '0;
  time_t             second_time = '0;
  time_t             livetime = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [FRAC_W-1:0] fraction;
  time_t             exposure;
  logic              in_good_time;
  logic              past_last;

  int    fail_count;
  int    rows_pending;
  int    items_sent = 0;
  int    stall_cycles = 0;
  logic  no_gaps = 1'b0;
  time_t table_pts[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gti_overlap_fraction u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .first_time_i   (first_time),
    .second_time_i  (second_time),
    .livetime_i     (livetime),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .fraction_o     (fraction),
    .exposure_o     (exposure),
    .in_good_time_o (in_good_time),
    .past_last_o    (past_last)
  );

  gof_result_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .action_i       (action),
    .first_time_i   (first_time),
    .second_time_i  (second_time),
    .livetime_i     (livetime),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .fraction_i     (fraction),
    .exposure_i     (exposure),
    .in_good_time_i (in_good_time),
    .past_last_i    (past_last),
    .fail_count_o   (fail_count),
    .rows_pending_o (rows_pending)
  );

  always @(negedge clk) begin
    out_ready <= no_gaps || ($urandom_range(0, 99) >= 20);
  end

  // Ends the run when neither channel completes a transaction for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic time_t rand48();
    return time_t'({$urandom, $urandom});
  endfunction

  function automatic time_t rand_live();
    case ($urandom_range(0, 3))
      0, 1:    return '0;
      2:       return time_t'($urandom_range(0, 100000));
      default: return rand48();
    endcase
  endfunction

  task automatic send_item(input logic [1:0] act, input time_t t_a, input time_t t_b,
                           input time_t t_live);
    @(negedge clk);
    while (!no_gaps && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    first_time  <= t_a;
    second_time <= t_b;
    livetime    <= t_live;
    do @(posedge clk); while (!in_ready);
    if (act != ACT_IGNORED) items_sent++;
    no_gaps = (items_sent >= 800) && (items_sent < 1000);
  endtask

  task automatic clear_table();
    send_item(ACT_CLEAR, rand48(), rand48(), rand48());
    table_pts.delete();
  endtask

  task automatic load_gti(input time_t t_begin, input time_t t_end);
    send_item(ACT_LOAD, t_begin, t_end, rand48());
    table_pts = {table_pts, t_begin, t_end};
  endtask

  // Rows are placed around interval edges, or anywhere on an empty table, to reach the overlap cases.
  task automatic row_near_table(input int sh);
    time_t anchor;
    time_t off;
    time_t t_a;
    time_t t_b;
    anchor = (table_pts.size() != 0) ? table_pts[$urandom_range(0, table_pts.size() - 1)]
                                     : rand48();
    off = time_t'($urandom_range(0, 1500)) << sh;
    t_a = $urandom_range(0, 1) ? anchor + off : anchor - off;
    if ($urandom_range(0, 9) == 0) t_b = t_a - (time_t'($urandom_range(1, 500)) << sh);
    else t_b = t_a + (time_t'($urandom_range(0, 3000)) << sh);
    send_item(ACT_ROW, t_a, t_b, rand_live());
  endtask

  initial begin
    int    kind;
    int    k;
    int    sh;
    time_t base;
    time_t cur;
    time_t b;
    time_t e;
    logic  full_done;
    full_done = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table: the whole row counts.
    send_item(ACT_ROW, '0, TIME_MAX, TIME_MAX);
    send_item(ACT_ROW, TIME_MAX, '0, '0);
    send_item(ACT_IGNORED, TIME_MAX, TIME_MAX, TIME_MAX);
    clear_table();
    load_gti(48'd1000, 48'd2000);
    load_gti(48'd3000, 48'd2500);
    load_gti(48'd5000, 48'd6000);
    load_gti(TIME_MAX - 48'd10, TIME_MAX);
    send_item(ACT_ROW, 48'd500, 48'd800, '0);
    send_item(ACT_ROW, 48'd500, 48'd1500, '0);
    send_item(ACT_ROW, 48'd500, 48'd3000, 48'd77777);
    send_item(ACT_ROW, 48'd1200, 48'd1800, '0);
    send_item(ACT_ROW, 48'd1500, 48'd2500, TIME_MAX);
    // Falls on the inverted interval, whose begin lies inside the row.
    send_item(ACT_ROW, 48'd2800, 48'd4000, '0);
    send_item(ACT_ROW, 48'd5500, 48'd5500, '0);
    send_item(ACT_ROW, 48'd4000, 48'd5000, '0);
    send_item(ACT_ROW, 48'd0, TIME_MAX, TIME_MAX);
    send_item(ACT_ROW, TIME_MAX, TIME_MAX - 48'd1, '0);
    clear_table();
    load_gti(48'd100, 48'd200);
    send_item(ACT_ROW, 48'd300, 48'd400, '0);
    send_item(ACT_ROW, TIME_MAX, TIME_MAX, TIME_MAX);
    send_item(ACT_ROW, 48'd199, 48'd202, '0);
    send_item(ACT_ROW, 48'd150, 48'd120, '0);

    while (items_sent < ROW_ITEMS) begin
      kind = $urandom_range(0, 99);
      sh   = $urandom_range(0, 24);
      if (kind < 75) begin
        clear_table();
        if (!full_done && items_sent >= 600) begin
          // Fill the table and push a few loads past its end.
          k         = TABLE_DEPTH + 3;
          sh        = $urandom_range(0, 20);
          full_done = 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
          k = $urandom_range(0, 40);
        end else begin
          k = $urandom_range(1, 8);
        end
        base = rand48() >> $urandom_range(0, 47);
        if (base > TIME_MAX - (time_t'(1) << 44)) base = base - (time_t'(1) << 44);
        cur = base;
        for (int j = 0; j < k; j++) begin
          b   = cur + (time_t'($urandom_range(0, 1000)) << sh);
          e   = b + (time_t'($urandom_range(0, 1000)) << sh);
          cur = e;
          if ($urandom_range(0, 9) == 0) load_gti(e, b);
          else load_gti(b, e);
        end
        repeat ($urandom_range(1, 8)) row_near_table(sh);
      end else if (kind < 90) begin
        send_item(2'($urandom_range(0, 3)), rand48(), rand48(), rand48());
      end else begin
        // Loads appended to whatever the table holds, unordered.
        repeat ($urandom_range(1, 3)) load_gti(rand48(), rand48());
        repeat ($urandom_range(1, 3)) row_near_table(sh);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (rows_pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/gof_pkg.sv
design/gti_overlap_fraction.sv
bench/gof_result_checker.sv
bench/gti_overlap_fraction_test.sv
